@@ rtl/crc32t_pkg.sv @@
// crc32t_pkg: shared types, command codes and crc-32 constants for frame_crc32_with_trailer.
// The trailer and state column tables are built here at elaboration from the polynomial.
// No dependencies.
package crc32t_pkg;

  localparam int CrcW        = 32;
  localparam int ByteW       = 8;
  localparam int TrailerBits = 168;  // 21 trailer bytes

  typedef logic [CrcW-1:0]  crc_t;
  typedef logic [ByteW-1:0] byte_t;

  localparam crc_t CRC_POLY = 32'hEDB8_8320;
  localparam crc_t CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ABSORB         = 2'd0,
    CMD_FINISH         = 2'd1,
    CMD_FINISH_TRAILER = 2'd2
  } cmd_t;

  typedef crc_t trailer_cols_t [TrailerBits];
  typedef crc_t state_cols_t   [CrcW];

  // one stage-register item handed from the trailer stage to the fold stage
  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
    byte_t data_byte;
    crc_t  trailer_crc;
  } stage_t;

  // reflected crc, one message bit
  function automatic crc_t shift_bit(crc_t c, logic b);
    logic fb;
    fb = c[0] ^ b;
    return (c >> 1) ^ (fb ? CRC_POLY : '0);
  endfunction

  function automatic crc_t fold_byte(crc_t c, byte_t b);
    crc_t acc;
    acc = c;
    for (int k = 0; k < ByteW; k++) begin
      acc = shift_bit(acc, b[k]);
    end
    return acc;
  endfunction

  // contribution of each trailer bit, starting from a zero crc
  function automatic trailer_cols_t build_trailer_cols();
    trailer_cols_t cols;
    crc_t          c;
    for (int j = 0; j < TrailerBits; j++) begin
      c = '0;
      for (int k = 0; k < TrailerBits; k++) begin
        c = shift_bit(c, (k == j));
      end
      cols[j] = c;
    end
    return cols;
  endfunction

  // image of each state bit after the trailer length of zero bits
  function automatic state_cols_t build_state_cols();
    state_cols_t cols;
    crc_t        c;
    for (int i = 0; i < CrcW; i++) begin
      c = crc_t'(1) << i;
      for (int k = 0; k < TrailerBits; k++) begin
        c = shift_bit(c, 1'b0);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam trailer_cols_t TRAILER_COL = build_trailer_cols();
  localparam state_cols_t   STATE_COL   = build_state_cols();

endpackage

@@ rtl/crc32t_trailer.sv @@
// crc32t_trailer: input stage register; folds the 21-byte trailer from a zero crc.
// Depends on crc32t_pkg.
module crc32t_trailer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  crc32t_pkg::byte_t       in_data_byte,
  input  logic [31:0]             in_block_id,
  input  logic [31:0]             in_packet_index,
  input  logic [7:0]              in_frame_type,
  input  logic [31:0]             in_payload_length,
  input  logic [63:0]             in_total_file_size,
  input  logic                    stage_adv,
  output crc32t_pkg::stage_t      stage
);
  import crc32t_pkg::*;

  logic [TrailerBits-1:0] trailer_bits;
  crc_t                   trailer_crc;
  logic                   in_fire;
  stage_t                 stage_r;
  stage_t                 stage_nxt;

  // byte 0 of the trailer sits in the low bits
  assign trailer_bits = {in_total_file_size, in_payload_length, in_frame_type,
                         in_packet_index, in_block_id};

  always_comb begin
    trailer_crc = '0;
    for (int k = 0; k < TrailerBits; k++) begin
      if (trailer_bits[k]) begin
        trailer_crc = trailer_crc ^ TRAILER_COL[k];
      end
    end
  end

  assign in_stall = stage_r.valid && !stage_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    stage_nxt = stage_r;
    if (in_fire) begin
      stage_nxt.valid       = 1'b1;
      stage_nxt.cmd         = cmd_t'(in_command);
      stage_nxt.data_byte   = in_data_byte;
      stage_nxt.trailer_crc = trailer_crc;
    end else if (stage_adv) begin
      stage_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage = stage_r;

endmodule

@@ rtl/crc32t_fold.sv @@
// crc32t_fold: running crc register and result register.
// Merges the stage item into the running crc; depends on crc32t_pkg.
module crc32t_fold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc32t_pkg::stage_t   stage,
  output logic                 stage_adv,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_crc_value
);
  import crc32t_pkg::*;

  crc_t running_crc_r;
  crc_t running_crc_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  crc_t out_crc_value_r;
  crc_t out_crc_value_nxt;
  crc_t shifted_crc;
  logic stage_fire;

  // running crc carried past the trailer length of zero bits
  always_comb begin
    shifted_crc = '0;
    for (int i = 0; i < CrcW; i++) begin
      if (running_crc_r[i]) begin
        shifted_crc = shifted_crc ^ STATE_COL[i];
      end
    end
  end

  assign stage_adv  = !(out_valid_r && out_stall);
  assign stage_fire = stage.valid && stage_adv;

  always_comb begin
    running_crc_nxt   = running_crc_r;
    out_crc_value_nxt = out_crc_value_r;
    out_valid_nxt     = out_valid_r && out_stall;
    if (stage_fire) begin
      case (stage.cmd)
        CMD_ABSORB: begin
          running_crc_nxt = fold_byte(running_crc_r, stage.data_byte);
        end
        CMD_FINISH: begin
          out_valid_nxt     = 1'b1;
          out_crc_value_nxt = running_crc_r ^ CRC_ONES;
          running_crc_nxt   = CRC_ONES;
        end
        CMD_FINISH_TRAILER: begin
          out_valid_nxt     = 1'b1;
          out_crc_value_nxt = shifted_crc ^ stage.trailer_crc ^ CRC_ONES;
          running_crc_nxt   = CRC_ONES;
        end
        default: begin
          // unused code: no result, state kept
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= CRC_ONES;
      out_valid_r   <= 1'b0;
    end else begin
      running_crc_r <= running_crc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_crc_value_r <= out_crc_value_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_value_r;

  a_finish_resets_crc: assert property (@(posedge clk) disable iff (!rst_n)
    stage_fire && (stage.cmd == CMD_FINISH || stage.cmd == CMD_FINISH_TRAILER)
    |=> running_crc_r == CRC_ONES)
    else $error("running crc not restored after finish");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stage_fire) &&
      ($past(stage.cmd) == CMD_FINISH || $past(stage.cmd) == CMD_FINISH_TRAILER))
    else $error("result appeared without a finish transaction");

  a_absorb_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    stage_fire && stage.cmd == CMD_ABSORB |=> !out_valid_r)
    else $error("absorb produced a result");

  a_unused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    stage_fire && stage.cmd != CMD_ABSORB && stage.cmd != CMD_FINISH &&
      stage.cmd != CMD_FINISH_TRAILER |=> $stable(running_crc_r))
    else $error("unused command changed the running crc");

  a_stage_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !stage_adv |=> stage.valid)
    else $error("stage item dropped while result blocked");

endmodule

@@ rtl/frame_crc32_with_trailer.sv @@
// frame_crc32_with_trailer: top level of the crc-32 block with optional frame trailer.
// Instantiates crc32t_trailer and crc32t_fold; depends on crc32t_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per byte or command.
//   in_command absorb folds in_data_byte into the running crc; finish emits
//   the crc; finish with trailer first folds the 21-byte little-endian trailer
//   (block id, packet index, frame type, payload length, file size).
//   Output channel (out_valid / out_stall): one transaction per finish with
//   out_crc_value; absorb and the unused command code give no result.
//   A finish passes through the input register and then the result register.
//   Throughput: one transaction per cycle when no held result stalls, set by the
//   running crc register update; the 21-byte trailer is folded in one pass through
//   a constant xor network split across the input and result registers.
//   Reset: running crc returns to all ones, both registers empty.
//   Stall: a held result blocks the fold stage; one more transaction can still
//   be taken into the input register before in_stall rises.
module frame_crc32_with_trailer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_block_id,
  input  logic [31:0] in_packet_index,
  input  logic [7:0]  in_frame_type,
  input  logic [31:0] in_payload_length,
  input  logic [63:0] in_total_file_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);
  import crc32t_pkg::*;

  stage_t stage;
  logic   stage_adv;

  crc32t_trailer u_trailer (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_block_id       (in_block_id),
    .in_packet_index   (in_packet_index),
    .in_frame_type     (in_frame_type),
    .in_payload_length (in_payload_length),
    .in_total_file_size(in_total_file_size),
    .stage_adv         (stage_adv),
    .stage             (stage)
  );

  crc32t_fold u_fold (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage        (stage),
    .stage_adv    (stage_adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_crc_value(out_crc_value)
  );

endmodule
